### rtl/core/pid_dd_pkg.sv
// ----------------------------------------------------------------------------
// pid_dd_pkg
// Shared widths, register indexes and the term bundle of the drive controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pid_dd_pkg;

    localparam int POS_W  = 13;
    localparam int GAIN_W = 16;
    localparam int SPD_W  = 8;
    localparam int ERR_W  = 14;
    localparam int INTG_W = 32;
    localparam int DER_W  = 15;
    localparam int CORR_W = 49;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_DERIV_GAIN  = 3'd2,
        REG_TARGET_POS  = 3'd3,
        REG_BASE_SPEED  = 3'd4,
        REG_MAX_SPEED   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [INTG_W-1:0] integ;
        logic signed [DER_W-1:0]  deriv;
    } t_terms;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
    } t_gains;

endpackage

### rtl/core/pid_dd_top.sv
// ----------------------------------------------------------------------------
// pid_differential_drive
// Line-following PID controller producing left and right motor duty and drive.
//
//   channel | direction | handshake                | payload
//   in      | input     | i_in_valid / o_in_ready  | i_line_position
//   out     | output    | o_out_valid / i_out_ready| o_left_pwm, o_left_drive,
//           |           |                          | o_right_pwm, o_right_drive
//   cfg     | input     | APB psel/penable/pready  | paddr, pwdata, prdata
//
// One transaction per cycle while the output is not stalled.
// The integral and previous error update at acceptance; the gain multiplies,
// sum, shift and clamp run between the term register and the result register.
// Synchronous active-low reset empties the pipeline and restores registers.
// A stalled result holds; a new transaction is taken while the term stage
// can move on or is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_differential_drive #(
    parameter int SENSOR_COUNT   = 8,
    parameter int GAIN_FRAC_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [pid_dd_pkg::POS_W-1:0]        i_line_position,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [pid_dd_pkg::SPD_W-1:0]        o_left_pwm,
    output logic                                o_left_drive,
    output logic [pid_dd_pkg::SPD_W-1:0]        o_right_pwm,
    output logic                                o_right_drive,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pid_dd_pkg::ADDR_W-1:0]       paddr,
    input  logic [pid_dd_pkg::DATA_W-1:0]       pwdata,
    output logic [pid_dd_pkg::DATA_W-1:0]       prdata,
    output logic                                pready
);
    import pid_dd_pkg::*;

    localparam logic [GAIN_W-1:0] KP_RST =
        GAIN_W'(((64'd1 << GAIN_FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [POS_W-1:0]  TGT_RST = POS_W'((SENSOR_COUNT - 1) * 500);
    localparam logic [SPD_W-1:0]  BASE_RST = SPD_W'(40);
    localparam logic [SPD_W-1:0]  MAX_RST  = SPD_W'(100);
    localparam int                SPD_CW   = CORR_W + 1;

    t_gains                     r_gains;
    logic [POS_W-1:0]           r_target;
    logic [SPD_W-1:0]           r_base;
    logic [SPD_W-1:0]           r_max;

    logic signed [INTG_W-1:0]   r_error_sum;
    logic signed [ERR_W-1:0]    r_prev_err;
    t_terms                     r_terms;
    logic                       r_s1_vld;
    logic                       r_out_vld;
    logic [SPD_W-1:0]           r_left_pwm;
    logic                       r_left_drive;
    logic [SPD_W-1:0]           r_right_pwm;
    logic                       r_right_drive;

    logic                       cfg_wr;
    t_reg_idx                   cfg_idx;
    logic                       in_acc;
    logic                       adv;
    logic signed [ERR_W-1:0]    n_err;
    logic signed [INTG_W:0]     acc_wide;
    logic signed [INTG_W-1:0]   n_error_sum;
    logic signed [DER_W-1:0]    n_deriv;
    logic signed [CORR_W-1:0]   corr;
    logic signed [SPD_CW-1:0]   base_x;
    logic signed [SPD_CW-1:0]   max_x;
    logic signed [SPD_CW-1:0]   left_spd;
    logic signed [SPD_CW-1:0]   right_spd;
    logic [SPD_W-1:0]           n_left_pwm;
    logic [SPD_W-1:0]           n_right_pwm;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.kp <= KP_RST;
            r_gains.ki <= '0;
            r_gains.kd <= '0;
            r_target   <= TGT_RST;
            r_base     <= BASE_RST;
            r_max      <= MAX_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PROP_GAIN:  r_gains.kp <= pwdata[GAIN_W-1:0];
                REG_INTEG_GAIN: r_gains.ki <= pwdata[GAIN_W-1:0];
                REG_DERIV_GAIN: r_gains.kd <= pwdata[GAIN_W-1:0];
                REG_TARGET_POS: r_target   <= pwdata[POS_W-1:0];
                REG_BASE_SPEED: r_base     <= pwdata[SPD_W-1:0];
                REG_MAX_SPEED:  r_max      <= pwdata[SPD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_PROP_GAIN:  prdata = DATA_W'(r_gains.kp);
            REG_INTEG_GAIN: prdata = DATA_W'(r_gains.ki);
            REG_DERIV_GAIN: prdata = DATA_W'(r_gains.kd);
            REG_TARGET_POS: prdata = DATA_W'(r_target);
            REG_BASE_SPEED: prdata = DATA_W'(r_base);
            REG_MAX_SPEED:  prdata = DATA_W'(r_max);
            default:        prdata = '0;
        endcase
    end

    // handshake
    assign adv        = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_s1_vld || adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // error, saturating integral, derivative
    assign n_err    = $signed({1'b0, r_target}) - $signed({1'b0, i_line_position});
    assign acc_wide = (INTG_W+1)'(r_error_sum) + (INTG_W+1)'(n_err);

    always_comb begin
        if (acc_wide[INTG_W] != acc_wide[INTG_W-1]) begin
            n_error_sum = acc_wide[INTG_W] ? {1'b1, {(INTG_W-1){1'b0}}}
                                           : {1'b0, {(INTG_W-1){1'b1}}};
        end else begin
            n_error_sum = acc_wide[INTG_W-1:0];
        end
    end

    assign n_deriv = DER_W'(n_err) - DER_W'(r_prev_err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum <= '0;
            r_prev_err  <= '0;
            r_s1_vld    <= 1'b0;
        end else begin
            if (in_acc) begin
                r_error_sum <= n_error_sum;
                r_prev_err  <= n_err;
                r_s1_vld    <= 1'b1;
            end else if (adv) begin
                r_s1_vld    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_terms.err   <= n_err;
            r_terms.integ <= n_error_sum;
            r_terms.deriv <= n_deriv;
        end
    end

    pid_dd_corr #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_corr (
        .i_terms (r_terms),
        .i_gains (r_gains),
        .o_corr  (corr)
    );

    // speeds and clamp
    assign base_x    = $signed({{(SPD_CW-SPD_W){1'b0}}, r_base});
    assign max_x     = $signed({{(SPD_CW-SPD_W){1'b0}}, r_max});
    assign left_spd  = base_x + SPD_CW'(corr);
    assign right_spd = base_x - SPD_CW'(corr);

    always_comb begin
        if (left_spd > max_x) begin
            n_left_pwm = r_max;
        end else if (left_spd > 0) begin
            n_left_pwm = left_spd[SPD_W-1:0];
        end else begin
            n_left_pwm = '0;
        end
        if (right_spd > max_x) begin
            n_right_pwm = r_max;
        end else if (right_spd > 0) begin
            n_right_pwm = right_spd[SPD_W-1:0];
        end else begin
            n_right_pwm = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_vld) begin
            r_left_pwm    <= n_left_pwm;
            r_left_drive  <= |n_left_pwm;
            r_right_pwm   <= n_right_pwm;
            r_right_drive <= |n_right_pwm;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_left_pwm    = r_left_pwm;
    assign o_left_drive  = r_left_drive;
    assign o_right_pwm   = r_right_pwm;
    assign o_right_drive = r_right_drive;

endmodule

### rtl/core/pid_dd_corr.sv
// ----------------------------------------------------------------------------
// pid_dd_corr
// Weighted sum of the three PID terms, scaled down with truncation toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_dd_corr #(
    parameter int GAIN_FRAC_BITS = 12
) (
    input  pid_dd_pkg::t_terms                          i_terms,
    input  pid_dd_pkg::t_gains                          i_gains,
    output logic signed [pid_dd_pkg::CORR_W-1:0]        o_corr
);
    import pid_dd_pkg::*;

    localparam logic [CORR_W-1:0] BIAS = CORR_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

    logic signed [GAIN_W+ERR_W-1:0]  p_term;
    logic signed [GAIN_W+INTG_W-1:0] i_term;
    logic signed [GAIN_W+DER_W-1:0]  d_term;
    logic signed [CORR_W-1:0]        sum;
    logic signed [CORR_W-1:0]        biased;

    assign p_term = i_gains.kp * i_terms.err;
    assign i_term = i_gains.ki * i_terms.integ;
    assign d_term = i_gains.kd * i_terms.deriv;

    assign sum = CORR_W'(p_term) + CORR_W'(i_term) + CORR_W'(d_term);

    // bias negative sums so the arithmetic shift truncates toward zero
    assign biased = sum[CORR_W-1] ? (sum + $signed(BIAS)) : sum;
    assign o_corr = biased >>> GAIN_FRAC_BITS;

endmodule
